[src/dwr_pkg.sv]
// Shared constants, types and codes for the deque with reverse.
package dwr_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = 5;
	localparam int VAL_W = 32;
	localparam int ACT_W = 2;
	localparam int IN_W  = 40;
	localparam int OUT_W = 40;

	localparam logic [ACT_W-1:0] ACT_INS_HEAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INS_TAIL = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REM_HEAD = 2'd2;
	localparam logic [ACT_W-1:0] ACT_REVERSE  = 2'd3;

	typedef struct packed {
		logic load;
		logic commit;
	} dwr_cmd_t;

endpackage

[src/dwr_ctrl.sv]
// Controller state machine: sequences accept, execute and output handshakes.
module dwr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output dwr_pkg::dwr_cmd_t cmd
);
	import dwr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	assign m_tvalid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

[src/dwr_datapath.sv]
// Datapath: slot memory, head pointer, count, direction flag and result register.
module dwr_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dwr_pkg::dwr_cmd_t         cmd,
	input  logic [dwr_pkg::ACT_W-1:0] in_action,
	input  logic [dwr_pkg::VAL_W-1:0] in_value,
	output logic                      res_ok,
	output logic [dwr_pkg::VAL_W-1:0] res_removed,
	output logic [dwr_pkg::CNT_W-1:0] res_count
);
	import dwr_pkg::*;

	logic [VAL_W-1:0] slots_q [DEPTH];
	logic [VAL_W-1:0] rd_data_q;
	logic [ACT_W-1:0] action_q;
	logic [VAL_W-1:0] value_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic             rev_q;

	logic [IDX_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	logic             rev_d;
	logic             ok_d;
	logic [VAL_W-1:0] removed_d;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] step_one;
	logic [IDX_W-1:0] off_cnt;
	logic [IDX_W-1:0] off_last;
	logic [IDX_W-1:0] head_in_slot;
	logic [IDX_W-1:0] tail_slot;
	logic [IDX_W-1:0] last_slot;
	logic [IDX_W-1:0] after_rem;

	// Ring offset helpers: forward and backward by k, k below DEPTH.
	function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0] base,
	                                              input logic [IDX_W-1:0] k);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, k};
		if (sum >= (IDX_W+1)'(DEPTH)) sum = sum - (IDX_W+1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] ring_back(input logic [IDX_W-1:0] base,
	                                               input logic [IDX_W-1:0] k);
		logic [IDX_W:0] dif;
		if (base >= k) dif = {1'b0, base} - {1'b0, k};
		else dif = {1'b0, base} + (IDX_W+1)'(DEPTH) - {1'b0, k};
		return dif[IDX_W-1:0];
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign step_one = IDX_W'(1);
	assign off_cnt  = count_q[IDX_W-1:0];
	assign off_last = IDX_W'(count_q - CNT_W'(1));

	assign head_in_slot = rev_q ? ring_fwd(front_q, step_one) : ring_back(front_q, step_one);
	assign tail_slot    = rev_q ? ring_back(front_q, off_cnt) : ring_fwd(front_q, off_cnt);
	assign last_slot    = rev_q ? ring_back(front_q, off_last) : ring_fwd(front_q, off_last);
	assign after_rem    = rev_q ? ring_back(front_q, step_one) : ring_fwd(front_q, step_one);

	always_comb begin
		front_d   = front_q;
		count_d   = count_q;
		rev_d     = rev_q;
		ok_d      = 1'b0;
		removed_d = '0;
		wr_en     = 1'b0;
		wr_addr   = head_in_slot;
		unique case (action_q)
			ACT_INS_HEAD: begin
				if (!full) begin
					front_d = head_in_slot;
					count_d = count_q + CNT_W'(1);
					wr_en   = 1'b1;
					ok_d    = 1'b1;
				end
			end
			ACT_INS_TAIL: begin
				wr_addr = tail_slot;
				if (!full) begin
					count_d = count_q + CNT_W'(1);
					wr_en   = 1'b1;
					ok_d    = 1'b1;
				end
			end
			ACT_REM_HEAD: begin
				if (!empty) begin
					removed_d = rd_data_q;
					front_d   = after_rem;
					count_d   = count_q - CNT_W'(1);
					ok_d      = 1'b1;
				end
			end
			ACT_REVERSE: begin
				if (!empty) begin
					front_d = last_slot;
					rev_d   = !rev_q;
				end
				ok_d = 1'b1;
			end
			default: ;
		endcase
	end

	// Slot memory: the head slot is read every cycle into a register; the
	// pointer only moves on commit, so the data is current when executing.
	always_ff @(posedge clk) begin
		rd_data_q <= slots_q[front_q];
		if (cmd.commit && wr_en) slots_q[wr_addr] <= value_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			value_q  <= in_value;
		end
		if (cmd.commit) begin
			res_ok      <= ok_d;
			res_removed <= removed_d;
			res_count   <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd.commit) begin
			front_q <= front_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

endmodule

[src/deque_with_reverse_unit.sv]
// Top level of the bounded double-ended queue with constant-time reverse.
//
// Usage: each slave-side transaction carries one command (insert at head,
// insert at tail, remove head, or reverse order) and an insert value. Every
// command produces exactly one master-side transaction with a success flag,
// the removed value (zero unless a remove succeeded) and the resulting count.
// The store holds up to DEPTH signed 32-bit values in a ring of slots; a
// reverse only flips a direction flag and moves the head pointer.
// Timing: an accepted command waits in the controller's execute state until
// the output register is free, then executes and its result is registered
// there. Commands are taken only in the idle state, so the next command is
// not accepted until the current one has executed. The head slot is read
// through a register that is current by the time the command executes.
// Stalls: the result sits in an output register; while it waits, the next
// command is still accepted, but it does not execute until the waiting
// result has been taken, so no result is ever dropped or overwritten.
// Reset: arst_n clears the count, head pointer, direction flag and all
// valid state; slot contents stay undefined until written.
module deque_with_reverse_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0: action[1:0], value[33:2], zero padding [39:34].
	input  logic [dwr_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// Fields from bit 0: ok[0], removed_value[32:1], count[37:33], zeros [39:38].
	output logic [dwr_pkg::OUT_W-1:0] m_tdata
);
	import dwr_pkg::*;

	dwr_cmd_t         cmd;
	logic             res_ok;
	logic [VAL_W-1:0] res_removed;
	logic [CNT_W-1:0] res_count;

	// The controller owns the handshakes and the sequencing.
	dwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds the ring, pointers and the result register.
	dwr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_action   (s_tdata[ACT_W-1:0]),
		.in_value    (s_tdata[ACT_W+VAL_W-1:ACT_W]),
		.res_ok      (res_ok),
		.res_removed (res_removed),
		.res_count   (res_count)
	);

	// Pack the result, zero-filled to whole bytes.
	assign m_tdata = {{(OUT_W-1-VAL_W-CNT_W){1'b0}}, res_count, res_removed, res_ok};

endmodule

[bench/deque_with_reverse_unit_tb.sv]
// Self-checking testbench for the bounded deque with constant-time reverse.
`timescale 1ns / 1ps

module deque_with_reverse_unit_tb;
	import dwr_pkg::*;

	// The random part is sized here. The last stretch runs with no idling on
	// either side. The receiver's long hold-off is meant to back the block up.
	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_ITEMS  = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_LIMIT  = 100;
	localparam int NUM_ROWS     = 12;

	// One expected result transaction, checked field by field against m_tdata.
	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] taken;
		logic [CNT_W-1:0] count;
	} deque_result_t;

	// One row of the directed table. A row is sent reps times. Where known is
	// set, the typed result replaces the predicted one.
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [VAL_W-1:0] val;
		logic [4:0]       reps;
		logic             known;
		logic             e_ok;
		logic [VAL_W-1:0] e_taken;
		logic [CNT_W-1:0] e_count;
	} stim_row_t;

	// Action mixes for the random part. They drive the store toward full,
	// toward empty, or keep it around the middle.
	typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} action_bias_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// The bench's own copy of the deque, which shadows the block's contents.
	logic [VAL_W-1:0]  ring_slot [DEPTH];
	int                head_idx = 0;
	int                fill_count = 0;
	bit                flipped = 1'b0;

	deque_result_t     pending_results [$];
	int                errors = 0;
	bit                quiet = 1'b0;
	bit                squeeze_req = 1'b0;
	bit                squeeze_started = 1'b0;
	int                hold_left = 0;
	int                burst_left = 0;
	bit                burst_ready = 1'b1;
	int                cycles = 0;

	// The directed table covers the empty cases, a tail insert into an empty
	// queue, both extremes of the value, a fill to capacity, and the inserts
	// and the reverse on a full store.
	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ACT_REM_HEAD, 32'h0000_0000, 5'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd0},
		'{ACT_REVERSE,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd0},
		'{ACT_INS_TAIL, 32'h8000_0000, 5'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd1},
		'{ACT_INS_HEAD, 32'h7fff_ffff, 5'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd2},
		'{ACT_REVERSE,  32'hffff_ffff, 5'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd2},
		'{ACT_REM_HEAD, 32'h1234_5678, 5'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
		'{ACT_INS_TAIL, 32'h5555_5555, 5'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
		'{ACT_INS_HEAD, 32'haaaa_aaaa, 5'd14, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
		'{ACT_INS_TAIL, 32'hffff_ffff, 5'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd16},
		'{ACT_INS_HEAD, 32'h0000_0000, 5'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd16},
		'{ACT_REVERSE,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd16},
		'{ACT_REM_HEAD, 32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0}
	};

	deque_with_reverse_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Reset is asserted from time zero. It is released once and never
	// asserted again.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Slot of logical element i. In normal order the elements run forward
	// from the head. In reversed order they run backward, modulo DEPTH.
	function automatic int slot_of(input int i);
		if (flipped) begin
			return (head_idx + DEPTH - (i % DEPTH)) % DEPTH;
		end
		return (head_idx + i) % DEPTH;
	endfunction

	// Applies one action to the shadow deque and gives back the result that
	// the block must answer with.
	task automatic deque_apply(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
			output deque_result_t res);
		res = '0;
		case (act)
			ACT_INS_HEAD: begin
				if (fill_count < DEPTH) begin
					// Going toward the head means stepping against the current order.
					head_idx = flipped ? (head_idx + 1) % DEPTH : (head_idx + DEPTH - 1) % DEPTH;
					ring_slot[head_idx] = val;
					fill_count++;
					res.ok = 1'b1;
				end
			end
			ACT_INS_TAIL: begin
				if (fill_count < DEPTH) begin
					ring_slot[slot_of(fill_count)] = val;
					fill_count++;
					res.ok = 1'b1;
				end
			end
			ACT_REM_HEAD: begin
				if (fill_count > 0) begin
					res.taken = ring_slot[head_idx];
					head_idx = flipped ? (head_idx + DEPTH - 1) % DEPTH : (head_idx + 1) % DEPTH;
					fill_count--;
					res.ok = 1'b1;
				end
			end
			ACT_REVERSE: begin
				// The last element becomes the head and the direction flips.
				// An empty queue is left as it is, but the action still succeeds.
				if (fill_count > 0) begin
					head_idx = slot_of(fill_count - 1);
					flipped = !flipped;
				end
				res.ok = 1'b1;
			end
		endcase
		res.count = fill_count[CNT_W-1:0];
	endtask

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (errors < PRINT_LIMIT) begin
			$display("%0t ns: mismatch in %s: want %h got %h", $realtime, what, want, got);
		end
		errors++;
	endtask

	// Offers one command and holds it until the block takes it. Before the
	// offer, s_tvalid may drop for a random burst. The prediction is made at
	// the edge where the transaction completes.
	task automatic send_command(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
			input bit idle_ok, input bit known, input deque_result_t typed);
		deque_result_t res;
		if (idle_ok && !quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - ACT_W - VAL_W){1'b0}}, val, act};
		do @(posedge clk); while (!s_tready);
		deque_apply(act, val, res);
		pending_results.push_back(known ? typed : res);
	endtask

	// Values lean toward the extremes and the all-ones pattern. Plain
	// random words still cover every bit.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ACT_W-1:0] pick_action(input action_bias_t bias);
		int roll;
		int ins_pct;
		int rem_pct;
		roll = $urandom_range(0, 99);
		case (bias)
			BIAS_FILL:  begin ins_pct = 70; rem_pct = 20; end
			BIAS_DRAIN: begin ins_pct = 20; rem_pct = 70; end
			default:    begin ins_pct = 45; rem_pct = 40; end
		endcase
		if (roll < ins_pct) begin
			return $urandom_range(0, 1) ? ACT_INS_TAIL : ACT_INS_HEAD;
		end
		if (roll < ins_pct + rem_pct) begin
			return ACT_REM_HEAD;
		end
		return ACT_REVERSE;
	endfunction

	// Main sequence: the directed table, then random segments with shifting
	// action mixes, then the drain and the verdict.
	initial begin : feed
		deque_result_t typed;
		action_bias_t  bias;
		int            seg_left;
		bit            seg_idle;
		bias = BIAS_FILL;
		seg_left = 0;
		seg_idle = 1'b1;
		while (!arst_n) @(posedge clk);
		@(posedge clk);

		foreach (directed_rows[r]) begin
			typed.ok    = directed_rows[r].e_ok;
			typed.taken = directed_rows[r].e_taken;
			typed.count = directed_rows[r].e_count;
			for (int k = 0; k < directed_rows[r].reps; k++) begin
				send_command(directed_rows[r].act, directed_rows[r].val, 1'b1,
					directed_rows[r].known, typed);
			end
		end

		// The receiver now stops for a long stretch while commands keep
		// coming, so the block has to stall its input.
		squeeze_req = 1'b1;
		typed = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				bias = action_bias_t'($urandom_range(0, 2));
				seg_left = $urandom_range(10, 40);
				seg_idle = $urandom_range(0, 2) != 0;
			end
			seg_left--;
			if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
				quiet = 1'b1;
			end
			send_command(pick_action(bias), pick_value(), seg_idle, 1'b0, typed);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// The result side checks each completed transaction against the oldest
	// expectation. It then chooses m_tready for the next cycle: the one long
	// hold-off, random bursts of stalls and of readiness, or steady readiness
	// at the end.
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", '0, m_tdata[VAL_W-1:0]);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[0] !== want.ok) begin
						report_mismatch("ok", {31'b0, want.ok}, {31'b0, m_tdata[0]});
					end
					if (m_tdata[VAL_W:1] !== want.taken) begin
						report_mismatch("removed_value", want.taken, m_tdata[VAL_W:1]);
					end
					if (m_tdata[VAL_W+CNT_W:VAL_W+1] !== want.count) begin
						report_mismatch("count", {27'b0, want.count},
							{27'b0, m_tdata[VAL_W+CNT_W:VAL_W+1]});
					end
				end
			end

			if (squeeze_req && !squeeze_started) begin
				squeeze_started = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				if (burst_left == 0) begin
					burst_ready = $urandom_range(0, 2) != 0;
					burst_left = $urandom_range(1, 16);
				end
				burst_left--;
				m_tready <= burst_ready;
			end
		end
	end

	// The run stops here if it hangs. The limit is many times the slowest
	// correct run.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/dwr_pkg.sv
src/dwr_ctrl.sv
src/dwr_datapath.sv
src/deque_with_reverse_unit.sv
bench/deque_with_reverse_unit_tb.sv
